@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lruws_pkg.sv @@
package lruws_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;

    localparam int CMD_W   = 3;
    localparam int IN_KEY_W = 32;
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int STAMP_W = 31;
    localparam int THR_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_CHECK  = 3'd1,
        CMD_TOUCH  = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_PRUNE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MOVE_WR,
        S_PRN_RD,
        S_PRN_EV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic add_direct;
        logic scan_step;
        logic scan_fin;
        logic touch_wr;
        logic remove;
        logic move_wr;
        logic prn_rd;
        logic idx_inc;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             add_full;
        logic             bad;
        logic             thr_neg;
        logic             scan_done;
        logic             move_needed;
        logic             idx_lt_count;
        logic             prn_remove;
        logic             out_free;
    } dp_sts_t;

endpackage

@@ sv/lruws_ctrl.sv @@
module lruws_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lruws_pkg::dp_sts_t sts,
    output lruws_pkg::dp_cmd_t ctl
);
    import lruws_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_ADD:    state_next = sts.add_full ? S_SCAN : S_DONE;
                    CMD_CHECK:  state_next = S_SCAN;
                    CMD_DELETE:
                    begin
                        if (!sts.bad && sts.move_needed)
                        begin
                            state_next = S_MOVE_WR;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_PRUNE:  state_next = sts.thr_neg ? S_DONE : S_PRN_RD;
                    default:    state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE_WR:
            begin
                state_next = (sts.cmd == CMD_PRUNE) ? S_PRN_RD : S_DONE;
            end
            S_PRN_RD:
            begin
                state_next = sts.idx_lt_count ? S_PRN_EV : S_DONE;
            end
            S_PRN_EV:
            begin
                if (sts.prn_remove && sts.move_needed)
                begin
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    state_next = S_PRN_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                ctl.capture = in_valid;
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_ADD:    ctl.add_direct = !sts.add_full;
                    CMD_TOUCH:  ctl.touch_wr   = !sts.bad;
                    CMD_DELETE: ctl.remove     = !sts.bad;
                    default:    ctl = '0;
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_step = !sts.scan_done;
                ctl.scan_fin  = sts.scan_done;
            end
            S_MOVE_WR:
            begin
                ctl.move_wr = 1'b1;
            end
            S_PRN_RD:
            begin
                ctl.prn_rd = sts.idx_lt_count;
            end
            S_PRN_EV:
            begin
                ctl.remove  = sts.prn_remove;
                ctl.idx_inc = !sts.prn_remove;
            end
            S_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default: ctl = '0;
        endcase
    end

endmodule

@@ sv/lruws_dp.sv @@
module lruws_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lruws_pkg::dp_cmd_t                   ctl,
    output lruws_pkg::dp_sts_t                   sts,
    input  logic [lruws_pkg::CMD_W-1:0]          command,
    input  logic [lruws_pkg::IN_KEY_W-1:0]       entry_key,
    input  logic [lruws_pkg::IDX_W-1:0]          slot_index,
    input  logic [lruws_pkg::STAMP_W-1:0]        now_stamp,
    input  logic signed [lruws_pkg::THR_W-1:0]   age_threshold,
    input  logic                                 cfg_valid,
    input  logic [lruws_pkg::CAP_W-1:0]          cfg_data,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [lruws_pkg::IDX_W-1:0]          result_slot,
    output logic                                 hit,
    output logic [lruws_pkg::CNT_W-1:0]          entry_count,
    output logic                                 bad_slot
);
    import lruws_pkg::*;

    logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
    logic [STAMP_W-1:0]  stamp_mem [MAX_ENTRIES];

    logic [CMD_W-1:0]        cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [STAMP_W-1:0]      now_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic                    bad_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   ev_idx_reg;
    logic               ev_valid_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic               out_valid_reg;

    logic [CAP_W-1:0]   eff_cap;
    logic [CNT_W-1:0]   cnt_dec;
    logic [IDX_W-1:0]   move_tgt;
    logic               idx_lt_count;
    logic               key_match;
    logic               cap_full;
    logic               in_bad;

    logic                wr_key_en;
    logic                wr_stamp_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_key;
    logic [STAMP_W-1:0]  wr_stamp;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (cap_reg > CAP_W'(MAX_ENTRIES))
        begin
            eff_cap = CAP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign cnt_dec      = count_reg - CNT_W'(1);
    assign move_tgt     = (cmd_reg == CMD_DELETE) ? slot_reg : idx_reg[IDX_W-1:0];
    assign idx_lt_count = (idx_reg < count_reg);
    assign key_match    = (rd_key_reg == key_reg);
    assign cap_full     = (CAP_W'(count_reg) >= eff_cap);
    assign in_bad       = ((command == CMD_TOUCH) || (command == CMD_DELETE)) &&
                          !(CNT_W'(slot_index) < count_reg);

    always_comb
    begin
        sts.cmd          = cmd_reg;
        sts.add_full     = cap_full;
        sts.bad          = bad_reg;
        sts.thr_neg      = thr_reg[THR_W-1];
        sts.scan_done    = found_reg || (!idx_lt_count && !ev_valid_reg);
        sts.move_needed  = (CNT_W'(move_tgt) != cnt_dec);
        sts.idx_lt_count = idx_lt_count;
        sts.prn_remove   = (THR_W'(rd_stamp_reg) < $unsigned(thr_reg)) &&
                           (count_reg > CNT_W'(1));
        sts.out_free     = !out_valid_reg || !out_stall;
    end

    // single write port shared by all commands
    always_comb
    begin
        wr_key_en   = 1'b0;
        wr_stamp_en = 1'b0;
        wr_addr     = '0;
        wr_key      = key_reg;
        wr_stamp    = now_reg;
        if (ctl.add_direct)
        begin
            wr_key_en   = 1'b1;
            wr_stamp_en = 1'b1;
            wr_addr     = count_reg[IDX_W-1:0];
        end
        else if (ctl.scan_fin)
        begin
            wr_addr     = best_idx_reg;
            wr_key_en   = (cmd_reg == CMD_ADD);
            wr_stamp_en = (cmd_reg == CMD_ADD) || found_reg;
        end
        else if (ctl.touch_wr)
        begin
            wr_stamp_en = 1'b1;
            wr_addr     = slot_reg;
        end
        else if (ctl.move_wr)
        begin
            wr_key_en   = 1'b1;
            wr_stamp_en = 1'b1;
            wr_addr     = move_tgt;
            wr_key      = rd_key_reg;
            wr_stamp    = rd_stamp_reg;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (ctl.scan_step && idx_lt_count)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[IDX_W-1:0];
        end
        else if (ctl.prn_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[IDX_W-1:0];
        end
        else if (ctl.remove)
        begin
            rd_en   = 1'b1;
            rd_addr = cnt_dec[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_W'(MAX_ENTRIES);
            idx_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end

            if (ctl.add_direct)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctl.remove)
            begin
                count_reg <= cnt_dec;
            end

            if (ctl.capture)
            begin
                idx_reg <= '0;
            end
            else if ((ctl.scan_step && idx_lt_count) || ctl.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (ctl.capture)
            begin
                ev_valid_reg <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                ev_valid_reg <= idx_lt_count;
            end

            if (ctl.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (ctl.scan_step && ev_valid_reg && (cmd_reg == CMD_CHECK) && key_match)
            begin
                found_reg <= 1'b1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            key_reg  <= entry_key[KEY_BITS-1:0];
            slot_reg <= slot_index;
            now_reg  <= now_stamp;
            thr_reg  <= age_threshold;
            bad_reg  <= in_bad;
        end

        if (ctl.scan_step && idx_lt_count)
        begin
            ev_idx_reg <= idx_reg[IDX_W-1:0];
        end

        // oldest stamp wins, strict compare keeps the lowest index on a tie
        if (ctl.capture)
        begin
            best_idx_reg   <= '0;
            best_stamp_reg <= '0;
        end
        else if (ctl.add_direct)
        begin
            best_idx_reg <= count_reg[IDX_W-1:0];
        end
        else if (ctl.scan_step && ev_valid_reg)
        begin
            if (cmd_reg == CMD_ADD)
            begin
                if ((ev_idx_reg == '0) || (best_stamp_reg > rd_stamp_reg))
                begin
                    best_idx_reg   <= ev_idx_reg;
                    best_stamp_reg <= rd_stamp_reg;
                end
            end
            else if (!found_reg && key_match)
            begin
                best_idx_reg <= ev_idx_reg;
            end
        end

        if (ctl.out_load)
        begin
            if ((cmd_reg == CMD_ADD) || ((cmd_reg == CMD_CHECK) && found_reg))
            begin
                result_slot <= best_idx_reg;
            end
            else
            begin
                result_slot <= '0;
            end
            hit         <= (cmd_reg == CMD_CHECK) && found_reg;
            bad_slot    <= bad_reg;
            entry_count <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/lru_working_set_table.sv @@
// LRU working-set table of keys with last-access stamps.
// Request channel: in_valid / in_stall with command, entry_key, slot_index,
// now_stamp and age_threshold; one request in flight, in_stall is high while
// a request is being worked on.
// Result channel: out_valid / out_stall with result_slot, hit, entry_count
// and bad_slot; exactly one result per request, held in an output register.
// Config: cfg_valid / cfg_ready writes capacity_limit; cfg_ready is always high.
// Add below capacity, touch, bad-slot and unknown commands go straight to
// the result; delete may first move the last entry into the freed slot; add
// when full and check scan the entries (one key/stamp RAM read per cycle,
// registered); prune reads each slot in turn and removes one by moving the
// last entry in, which is then read again. A new request is taken the cycle
// after the result is loaded.
// Reset clears the entry count and sets capacity to 16; stored keys and
// stamps are not cleared.
// A stalled result stays put; the next result waits in its final state
// until the output register is free, holding in_stall high meanwhile.
module lru_working_set_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lruws_pkg::CMD_W-1:0]          command,
    input  logic [lruws_pkg::IN_KEY_W-1:0]       entry_key,
    input  logic [lruws_pkg::IDX_W-1:0]          slot_index,
    input  logic [lruws_pkg::STAMP_W-1:0]        now_stamp,
    input  logic signed [lruws_pkg::THR_W-1:0]   age_threshold,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lruws_pkg::CAP_W-1:0]          cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lruws_pkg::IDX_W-1:0]          result_slot,
    output logic                                 hit,
    output logic [lruws_pkg::CNT_W-1:0]          entry_count,
    output logic                                 bad_slot
);
    import lruws_pkg::*;

    dp_cmd_t ctl;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    lruws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    lruws_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .command       (command),
        .entry_key     (entry_key),
        .slot_index    (slot_index),
        .now_stamp     (now_stamp),
        .age_threshold (age_threshold),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .result_slot   (result_slot),
        .hit           (hit),
        .entry_count   (entry_count),
        .bad_slot      (bad_slot)
    );

endmodule

@@ sv/lruws_checker.sv @@
`include "assert_macros.svh"

module lruws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [lruws_pkg::IDX_W-1:0]  result_slot,
    input logic                         hit,
    input logic [lruws_pkg::CNT_W-1:0]  entry_count,
    input logic                         bad_slot
);
    import lruws_pkg::*;

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_slot) && $stable(entry_count), "stalled result changed")

    `ASSERT_IMPLY(a_count_max, out_valid, entry_count <= CNT_W'(MAX_ENTRIES), "entry count above table size")

    `ASSERT_IMPLY(a_hit_slot, out_valid && hit, CNT_W'(result_slot) < entry_count, "hit slot not below count")

    `ASSERT_IMPLY(a_bad_clean, out_valid && bad_slot, !hit && (result_slot == '0), "bad slot with hit or slot")

endmodule

bind lru_working_set_table lruws_checker u_lruws_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import lruws_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [IN_KEY_W-1:0] key;
        logic [IDX_W-1:0]    slot;
        logic [STAMP_W-1:0]  stamp;
        logic [THR_W-1:0]    thr;
    } table_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic             hit;
        logic [CNT_W-1:0] count;
        logic             bad;
    } table_rsp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    table_req_t             cur_req = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data = 5'd16;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [IDX_W-1:0]       result_slot;
    logic                   hit;
    logic [CNT_W-1:0]       entry_count;
    logic                   bad_slot;

    // shadow copy of the table
    logic [IN_KEY_W-1:0]    shadow_keys [MAX_ENTRIES];
    logic [STAMP_W-1:0]     shadow_stamps [MAX_ENTRIES];
    int unsigned            shadow_count = 0;
    logic [CAP_W-1:0]       shadow_cap = 5'd16;

    table_req_t             pending_reqs [$];
    table_rsp_t             due_results [$];
    int unsigned            queued_count = 0;
    int unsigned            sent_count = 0;
    int unsigned            cfg_writes = 0;
    int unsigned            failures = 0;
    int unsigned            stuck_cycles = 0;
    logic                   req_taken = 1'b0;
    logic                   calm = 1'b0;

    int unsigned            src_gap = 0;
    int unsigned            src_quiet = 0;
    int unsigned            sink_burst = 0;
    int unsigned            sink_quiet = 0;

    lru_working_set_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (cur_req.cmd),
        .entry_key     (cur_req.key),
        .slot_index    (cur_req.slot),
        .now_stamp     (cur_req.stamp),
        .age_threshold (cur_req.thr),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_slot   (result_slot),
        .hit           (hit),
        .entry_count   (entry_count),
        .bad_slot      (bad_slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void drop_slot(int unsigned s);
        if (s < shadow_count)
        begin
            shadow_count--;
            if (s != shadow_count)
            begin
                shadow_keys[s]   = shadow_keys[shadow_count];
                shadow_stamps[s] = shadow_stamps[shadow_count];
            end
        end
    endfunction

    function automatic table_rsp_t apply_request(table_req_t r);
        table_rsp_t  rsp;
        int unsigned lim;
        int unsigned victim;
        int unsigned i;
        rsp = '0;
        if (shadow_cap == 0)
            lim = 1;
        else if (shadow_cap > MAX_ENTRIES)
            lim = MAX_ENTRIES;
        else
            lim = 32'(shadow_cap);
        case (r.cmd)
            CMD_ADD:
            begin
                if (shadow_count >= lim)
                begin
                    victim = 0;
                    for (i = 1; i < shadow_count; i++)
                        if (shadow_stamps[victim] > shadow_stamps[i])
                            victim = i;
                end
                else
                begin
                    victim = shadow_count;
                    shadow_count++;
                end
                shadow_keys[victim]   = r.key;
                shadow_stamps[victim] = r.stamp;
                rsp.slot = victim[IDX_W-1:0];
            end
            CMD_CHECK:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_keys[i] == r.key)
                    begin
                        shadow_stamps[i] = r.stamp;
                        rsp.hit  = 1'b1;
                        rsp.slot = i[IDX_W-1:0];
                        break;
                    end
                end
            end
            CMD_TOUCH:
            begin
                if (r.slot < shadow_count)
                    shadow_stamps[r.slot] = r.stamp;
                else
                    rsp.bad = 1'b1;
            end
            CMD_DELETE:
            begin
                if (r.slot < shadow_count)
                    drop_slot(32'(r.slot));
                else
                    rsp.bad = 1'b1;
            end
            CMD_PRUNE:
            begin
                // negative bound leaves the table alone; a moved entry is re-examined
                if (!r.thr[THR_W-1])
                begin
                    i = 0;
                    while (i < shadow_count)
                    begin
                        if ({1'b0, shadow_stamps[i]} < r.thr && shadow_count > 1)
                            drop_slot(i);
                        else
                            i++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.count = shadow_count[CNT_W-1:0];
        return rsp;
    endfunction

    // sampling and checking
    always @(posedge clk)
    begin : monitor
        logic       progress;
        table_rsp_t want;
        if (rst_n)
        begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                shadow_cap = cfg_data;
                cfg_writes++;
                progress = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                due_results.push_back(apply_request(cur_req));
                sent_count++;
                progress = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: slot %0d hit %0d count %0d bad %0d",
                           result_slot, hit, entry_count, bad_slot);
                    failures++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_slot !== want.slot)
                    begin
                        $error("result_slot: expected %0d, actual %0d", want.slot, result_slot);
                        failures++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                        failures++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
                        failures++;
                    end
                    if (bad_slot !== want.bad)
                    begin
                        $error("bad_slot: expected %0d, actual %0d", want.bad, bad_slot);
                        failures++;
                    end
                end
            end
            req_taken    <= in_valid && !in_stall;
            stuck_cycles <= progress ? 0 : stuck_cycles + 1;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (!calm)
                begin
                    if (src_quiet > 0)
                        src_quiet--;
                    else if ($urandom_range(0, 1))
                        src_gap = $urandom_range(1, 17);
                    else
                        src_quiet = $urandom_range(1, 30);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (!calm && sink_burst > 0)
        begin
            sink_burst--;
            out_stall <= 1'b1;
        end
        else if (calm || sink_quiet > 0)
        begin
            if (sink_quiet > 0)
                sink_quiet--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 1))
        begin
            sink_burst = $urandom_range(1, 17) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            sink_quiet = $urandom_range(1, 40);
            out_stall <= 1'b0;
        end
    end

    task automatic enqueue(table_req_t r);
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    task automatic cmd_item(logic [CMD_W-1:0] c, logic [IN_KEY_W-1:0] k,
                            logic [IDX_W-1:0] s, logic [STAMP_W-1:0] st,
                            logic [THR_W-1:0] th);
        table_req_t r;
        r.cmd   = c;
        r.key   = k;
        r.slot  = s;
        r.stamp = st;
        r.thr   = th;
        enqueue(r);
    endtask

    task automatic drain;
        do
            @(negedge clk);
        while (sent_count != queued_count || due_results.size() != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        int unsigned mark;
        drain();
        repeat (4) @(negedge clk);
        mark = cfg_writes;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_writes == mark);
        cfg_valid <= 1'b0;
    endtask

    // random traffic with reserved commands: small key pool, mostly rising clock, bounds mostly near now
    task automatic fill_random(int unsigned n);
        logic [IN_KEY_W-1:0] pool [10];
        logic [STAMP_W-1:0]  clock_now;
        int unsigned         k;
        int unsigned         pick;
        table_req_t          r;
        pool[0] = '0;
        pool[1] = '1;
        for (k = 2; k < 10; k++)
            pool[k] = $urandom;
        clock_now = STAMP_W'($urandom_range(0, 32'h7FFF_0000));
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 36)
                r.cmd = CMD_ADD;
            else if (pick < 60)
                r.cmd = CMD_CHECK;
            else if (pick < 72)
                r.cmd = CMD_TOUCH;
            else if (pick < 84)
                r.cmd = CMD_DELETE;
            else if (pick < 95)
                r.cmd = CMD_PRUNE;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       r.cmd = CMD_RSVD_5;
                    1:       r.cmd = CMD_RSVD_6;
                    default: r.cmd = CMD_RSVD_7;
                endcase
            end
            r.key  = ($urandom_range(0, 9) != 0) ? pool[$urandom_range(0, 9)] : $urandom;
            r.slot = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 7))
                                                : IDX_W'($urandom_range(0, 15));
            clock_now = clock_now + STAMP_W'($urandom_range(0, 3));
            r.stamp = ($urandom_range(0, 19) == 0) ? STAMP_W'($urandom) : clock_now;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r.thr = {1'b0, clock_now} - $urandom_range(0, 40);
                6:                r.thr = $urandom | 32'h8000_0000;
                7:                r.thr = '0;
                8:                r.thr = 32'h7FFF_FFFF;
                default:          r.thr = $urandom;
            endcase
            enqueue(r);
        end
    endtask

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("lru_working_set_table verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [CAP_W-1:0] caps [RAND_PHASES];
        int unsigned      p;
        caps = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd3, 5'd16, 5'd12, 5'd5};
        caps[RAND_PHASES-1] = CAP_W'($urandom_range(1, 16));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, capacity from reset
        cmd_item(CMD_CHECK,  '0, 4'd0,  31'd1, '0);
        cmd_item(CMD_TOUCH,  '0, 4'd0,  31'd1, '0);
        cmd_item(CMD_DELETE, '0, 4'd15, 31'd1, '0);
        cmd_item(CMD_PRUNE,  '0, 4'd0,  31'd1, 32'h7FFF_FFFF);
        cmd_item(CMD_ADD,    '0, 4'd0,  31'd0, '0);
        cmd_item(CMD_ADD,    '1, 4'd15, 31'h7FFF_FFFF, '1);
        cmd_item(CMD_ADD,    32'h1234_5678, 4'd0, 31'd5, '0);
        cmd_item(CMD_CHECK,  '1, 4'd0, 31'd9, '0);
        cmd_item(CMD_CHECK,  32'hDEAD_BEEF, 4'd0, 31'd9, '0);
        cmd_item(CMD_TOUCH,  '0, 4'd2,  31'd100, '0);
        cmd_item(CMD_TOUCH,  '0, 4'd3,  31'd100, '0);
        cmd_item(CMD_TOUCH,  '0, 4'd15, 31'd100, '0);
        cmd_item(CMD_RSVD_5, '1, 4'd15, '1, '1);
        cmd_item(CMD_RSVD_6, '1, 4'd1,  '1, '1);
        cmd_item(CMD_RSVD_7, '0, 4'd0,  '0, '0);
        cmd_item(CMD_PRUNE,  '0, 4'd0,  31'd0, 32'hFFFF_FFFF);
        cmd_item(CMD_PRUNE,  '0, 4'd0,  31'd0, 32'h8000_0000);
        cmd_item(CMD_PRUNE,  '0, 4'd0,  31'd0, 32'd50);
        cmd_item(CMD_ADD,    32'hA5A5_A5A5, 4'd0, 31'd200, '0);
        cmd_item(CMD_DELETE, '0, 4'd1,  31'd0, '0);
        cmd_item(CMD_ADD,    32'h5A5A_5A5A, 4'd0, 31'd210, '0);
        cmd_item(CMD_ADD,    32'h0F0F_0F0F, 4'd0, 31'd220, '0);
        cmd_item(CMD_DELETE, '0, 4'd0,  31'd0, '0);
        cmd_item(CMD_PRUNE,  '0, 4'd0,  31'd0, 32'h7FFF_FFFF);

        // small capacity: replacement and stamp ties
        write_capacity(5'd2);
        cmd_item(CMD_ADD,   32'd1, 4'd0, 31'd7, '0);
        cmd_item(CMD_ADD,   32'd2, 4'd0, 31'd7, '0);
        cmd_item(CMD_ADD,   32'd3, 4'd0, 31'd7, '0);
        cmd_item(CMD_CHECK, 32'd3, 4'd0, 31'd8, '0);

        for (p = 0; p < RAND_PHASES; p++)
        begin
            write_capacity(caps[p]);
            if (p == RAND_PHASES - 1)
                calm = 1'b1;
            fill_random(PHASE_ITEMS);
        end

        drain();
        repeat (40) @(negedge clk);
        if (failures == 0)
            $display("lru_working_set_table verification clean");
        else
            $display("lru_working_set_table verification failed");
        $finish;
    end

endmodule
